// ===== rtl/bsr_pkg.sv =====
// bsr_pkg: shared types and codes for the byte stack with reverse.
// Operation and status codes, field widths and the sequencer state type.
// No dependencies.
`default_nettype none

package bsr_pkg;

   // field widths
   localparam int unsigned OP_W   = 2;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned ST_W   = 2;
   localparam int unsigned FILL_W = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
   localparam logic [OP_W-1:0] OP_POP     = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
   localparam logic [OP_W-1:0] OP_REVERSE = 2'd3;

   // status codes
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH_WR,
      S_READ_DONE,
      S_REV_RD_LO,
      S_REV_RD_HI,
      S_REV_WR_LO,
      S_REV_WR_HI
   } bsr_state_type;

endpackage : bsr_pkg

`default_nettype wire

// ===== rtl/byte_stack_with_reverse_unit.sv =====
// byte_stack_with_reverse_unit: top level of the byte-wide LIFO stack with in-place reverse.
// Depends on bsr_pkg and bsr_ram.
//
//   channel   ports                                       handshake
//   request   req_op, req_push_byte                       start & !busy
//   response  rsp_read_byte, rsp_status, rsp_fill_count   rsp_valid, one cycle
//
// Push writes the storage from its own state; pop and peek read the top entry while idle
// and answer from the registered read data. Errors and a reverse of fewer than two entries
// answer straight from the idle state. Reverse swaps floor(count / 2) pairs: each pair swap
// is two reads and two writes through the single read and single write port of the storage.
// busy is high from acceptance until the response cycle, but never rises for errors
// and trivial reverses; the response strobe lasts one cycle and the receiver cannot
// stall it. Synchronous reset empties the stack; storage contents are not cleared.
`default_nettype none

module byte_stack_with_reverse_unit #(
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [bsr_pkg::OP_W-1:0]     req_op,
   input  wire logic [bsr_pkg::BYTE_W-1:0]   req_push_byte,
   output logic                              rsp_valid,
   output logic      [bsr_pkg::BYTE_W-1:0]   rsp_read_byte,
   output logic      [bsr_pkg::ST_W-1:0]     rsp_status,
   output logic      [bsr_pkg::FILL_W-1:0]   rsp_fill_count
);
   import bsr_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   // state
   bsr_state_type     state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [BYTE_W-1:0] tmp_ff, tmp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [ST_W-1:0]   rsp_status_ff, rsp_status_in;

   // storage interface
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   // decoded conditions
   logic          accept;
   logic          is_full;
   logic          is_empty;
   logic          rev_trivial;
   logic [CW-1:0] count_m1;
   logic [AW-1:0] top_idx;
   logic [AW-1:0] span;
   logic          more_pairs;
   logic [CW+FILL_W-1:0] count_wide;

   assign accept      = start && (state_ff == S_IDLE);
   assign is_full     = (count_ff == CW'(DEPTH));
   assign is_empty    = (count_ff == '0);
   assign rev_trivial = (count_ff < CW'(2));
   assign count_m1    = count_ff - CW'(1);
   assign top_idx     = count_m1[AW-1:0];

   // index unit: distance between the swap pointers
   assign span       = hi_ff - lo_ff;
   assign more_pairs = ({1'b0, span} > (AW+1)'(2));

   bsr_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_op)
                  OP_PUSH: state_in = is_full ? S_IDLE : S_PUSH_WR;
                  OP_POP, OP_PEEK: state_in = is_empty ? S_IDLE : S_READ_DONE;
                  default: state_in = rev_trivial ? S_IDLE : S_REV_RD_LO;
               endcase
            end
         end
         S_PUSH_WR:   state_in = S_IDLE;
         S_READ_DONE: state_in = S_IDLE;
         S_REV_RD_LO: state_in = S_REV_RD_HI;
         S_REV_RD_HI: state_in = S_REV_WR_LO;
         S_REV_WR_LO: state_in = S_REV_WR_HI;
         S_REV_WR_HI: state_in = more_pairs ? S_REV_RD_LO : S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      op_in         = op_ff;
      byte_in       = byte_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      tmp_in        = tmp_ff;
      rsp_valid_in  = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = lo_ff;
      ram_wr_data   = tmp_ff;
      ram_rd_addr   = lo_ff;
      case (state_ff)
         S_IDLE: begin
            // read the top entry ahead of a pop or peek
            ram_rd_addr = top_idx;
            if (accept) begin
               op_in   = req_op;
               byte_in = req_push_byte;
               lo_in   = '0;
               hi_in   = top_idx;
               // answer errors and trivial reverses at once
               case (req_op)
                  OP_PUSH: begin
                     if (is_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_byte_in   = '0;
                        rsp_status_in = ST_FULL;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_byte_in   = '0;
                        rsp_status_in = ST_EMPTY;
                     end
                  end
                  default: begin
                     if (rev_trivial) begin
                        rsp_valid_in  = 1'b1;
                        rsp_byte_in   = '0;
                        rsp_status_in = ST_OK;
                     end
                  end
               endcase
            end
         end
         S_PUSH_WR: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = count_ff[AW-1:0];
            ram_wr_data   = byte_ff;
            count_in      = count_ff + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = '0;
            rsp_status_in = ST_OK;
         end
         S_READ_DONE: begin
            if (op_ff == OP_POP) begin
               count_in = count_m1;
            end
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = ram_rd_data;
            rsp_status_in = ST_OK;
         end
         S_REV_RD_LO: begin
            ram_rd_addr = lo_ff;
         end
         S_REV_RD_HI: begin
            ram_rd_addr = hi_ff;
            tmp_in      = ram_rd_data;
         end
         S_REV_WR_LO: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff;
            ram_wr_data = ram_rd_data;
         end
         S_REV_WR_HI: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hi_ff;
            ram_wr_data = tmp_ff;
            lo_in       = lo_ff + AW'(1);
            hi_in       = hi_ff - AW'(1);
            if (!more_pairs) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = '0;
               rsp_status_in = ST_OK;
            end
         end
         default: begin
            ram_rd_addr = lo_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      byte_ff       <= byte_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      tmp_ff        <= tmp_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
   end

   // count reported modulo 256
   assign count_wide = (CW + FILL_W)'(count_ff);

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = count_wide[FILL_W-1:0];

endmodule : byte_stack_with_reverse_unit

`default_nettype wire

// ===== rtl/bsr_ram.sv =====
// bsr_ram: stack storage, one write port and one read port with registered read data.
// Depends on bsr_pkg for the byte width.
`default_nettype none

module bsr_ram #(
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire logic [bsr_pkg::BYTE_W-1:0]   wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic      [bsr_pkg::BYTE_W-1:0]   rd_data
);
   import bsr_pkg::*;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered data in the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : bsr_ram

`default_nettype wire

// ===== verif/byte_stack_with_reverse_unit_tb.sv =====
// byte_stack_with_reverse_unit_tb: self-checking bench for the byte LIFO stack with reverse.
// Directed and random bursty requests are checked field by field against a behavioral stack model.
// Depends on bsr_pkg and byte_stack_with_reverse_unit.
`default_nettype none

module byte_stack_with_reverse_unit_tb;
   import bsr_pkg::*;

   localparam int unsigned DEPTH        = 128;
   localparam int unsigned RANDOM_ITEMS = 1750;
   localparam int unsigned IDLE_LIMIT   = 5000;
   localparam int unsigned TAIL_CYCLES  = 300;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] push_byte;
      logic              drain_first;   // hold until all responses are in
   } stack_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic [ST_W-1:0]   status;
      logic [FILL_W-1:0] fill_count;
   } stack_rsp_type;

   // op mix used by a random phase
   typedef enum logic [1:0] {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN,
      MIX_REVERSE
   } op_mix_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [OP_W-1:0]     req_op = '0;
   logic [BYTE_W-1:0]   req_push_byte = '0;
   logic                busy;
   logic                rsp_valid;
   logic [BYTE_W-1:0]   rsp_read_byte;
   logic [ST_W-1:0]     rsp_status;
   logic [FILL_W-1:0]   rsp_fill_count;

   // stack model state
   logic [BYTE_W-1:0]   model_mem [DEPTH];
   int unsigned         model_count = 0;

   stack_req_type       request_q [$];
   stack_rsp_type       predicted_rsp_q [$];
   int unsigned         issued_count = 0;
   int unsigned         accepted_count = 0;
   int unsigned         rsp_count = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         idle_cycles = 0;
   int unsigned         burst_left = 0;
   int unsigned         gap_left = 0;

   byte_stack_with_reverse_unit #(
      .DEPTH(DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_push_byte  (req_push_byte),
      .rsp_valid      (rsp_valid),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

   always #5 clock = ~clock;

   // apply one operation to the model stack and return its response
   function automatic stack_rsp_type apply_stack_op(input logic [OP_W-1:0] op,
                                                    input logic [BYTE_W-1:0] din);
      stack_rsp_type     r;
      int                lo;
      int                hi;
      logic [BYTE_W-1:0] tmp;
      r.read_byte = '0;
      r.status    = ST_OK;
      case (op)
         OP_PUSH: begin
            if (model_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               model_mem[model_count] = din;
               model_count++;
            end
         end
         OP_POP: begin
            if (model_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               model_count--;
               r.read_byte = model_mem[model_count];
            end
         end
         OP_PEEK: begin
            if (model_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.read_byte = model_mem[model_count-1];
            end
         end
         default: begin
            // swap pairs from both ends; fewer than two entries is a no-op
            lo = 0;
            hi = int'(model_count) - 1;
            while (lo < hi) begin
               tmp = model_mem[lo];
               model_mem[lo] = model_mem[hi];
               model_mem[hi] = tmp;
               lo++;
               hi--;
            end
         end
      endcase
      r.fill_count = model_count[FILL_W-1:0];
      return r;
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input op_mix_type mix);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:    return roll < 80 ? OP_PUSH : roll < 88 ? OP_POP :
                             roll < 94 ? OP_PEEK : OP_REVERSE;
         MIX_DRAIN:   return roll < 75 ? OP_POP : roll < 85 ? OP_PUSH :
                             roll < 93 ? OP_PEEK : OP_REVERSE;
         MIX_REVERSE: return roll < 40 ? OP_REVERSE : roll < 70 ? OP_PUSH :
                             roll < 85 ? OP_POP : OP_PEEK;
         default:     return roll < 25 ? OP_PUSH : roll < 50 ? OP_POP :
                             roll < 75 ? OP_PEEK : OP_REVERSE;
      endcase
   endfunction

   function automatic void add_req(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                                   input logic drain);
      stack_req_type item;
      item.op          = op;
      item.push_byte   = b;
      item.drain_first = drain;
      request_q.push_back(item);
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: response %0d %s expected 0x%0h got 0x%0h",
                     rsp_count, field, want, got);
      end
   endtask

   // driver: bursts of requests with random gaps, held until accepted
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && issued_count != accepted_count) begin
         // request still waiting for acceptance
      end else if (gap_left > 0) begin
         gap_left--;
         start <= 1'b0;
      end else if (request_q.size() == 0 ||
                   (request_q[0].drain_first && predicted_rsp_q.size() != 0)) begin
         start <= 1'b0;
      end else begin
         stack_req_type item;
         item = request_q.pop_front();
         req_op        <= item.op;
         req_push_byte <= item.push_byte;
         start         <= 1'b1;
         issued_count++;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end
   end

   // monitor: check responses, record accepted requests, watchdog
   always @(posedge clock) begin
      stack_rsp_type want;
      logic          progress;
      if (!reset) begin
         progress = 1'b0;
         if (rsp_valid) begin
            progress = 1'b1;
            if (predicted_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: response %0d with no request outstanding", rsp_count);
            end else begin
               want = predicted_rsp_q.pop_front();
               compare_field("read_byte", want.read_byte, rsp_read_byte);
               compare_field("status", want.status, rsp_status);
               compare_field("fill_count", want.fill_count, rsp_fill_count);
            end
            rsp_count++;
         end
         if (start && !busy) begin
            progress = 1'b1;
            predicted_rsp_q.push_back(apply_stack_op(req_op, req_push_byte));
            accepted_count++;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("byte_stack_with_reverse_unit_tb failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned made;
      int unsigned len;
      op_mix_type  mix;

      // directed: empty errors, single-entry reverse, even and odd reverse, drain to empty
      add_req(OP_PEEK, 8'($urandom_range(0, 255)), 1'b0);
      add_req(OP_POP, 8'($urandom_range(0, 255)), 1'b0);
      add_req(OP_REVERSE, 8'($urandom_range(0, 255)), 1'b0);
      add_req(OP_PUSH, 8'h00, 1'b0);
      add_req(OP_REVERSE, 8'hFF, 1'b0);
      add_req(OP_PEEK, 8'hFF, 1'b0);
      add_req(OP_PUSH, 8'hFF, 1'b0);
      add_req(OP_PUSH, 8'h80, 1'b0);
      add_req(OP_PUSH, 8'h01, 1'b0);
      add_req(OP_REVERSE, 8'h00, 1'b0);
      add_req(OP_PEEK, 8'h00, 1'b0);
      add_req(OP_PUSH, 8'h7F, 1'b0);
      add_req(OP_REVERSE, 8'hAA, 1'b0);
      add_req(OP_PEEK, 8'h55, 1'b0);
      for (int i = 0; i < 5; i++)
         add_req(OP_POP, 8'($urandom_range(0, 255)), 1'b0);
      add_req(OP_POP, 8'h00, 1'b0);
      add_req(OP_PEEK, 8'hFF, 1'b0);

      // random: open with a fill phase to reach overflow, then mixed phases
      made = 0;
      mix  = MIX_FILL;
      len  = 200;
      while (made < RANDOM_ITEMS) begin
         for (int i = 0; i < len && made < RANDOM_ITEMS; i++) begin
            add_req(pick_op(mix), 8'($urandom_range(0, 255)),
                    made == 0 || $urandom_range(0, 99) == 0);
            made++;
         end
         mix = op_mix_type'($urandom_range(0, 3));
         len = $urandom_range(20, 150);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for all requests to be accepted and answered, then a quiet tail
      while (request_q.size() != 0 || issued_count != accepted_count ||
             predicted_rsp_q.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("byte_stack_with_reverse_unit_tb passed");
      end else begin
         $display("byte_stack_with_reverse_unit_tb failed");
      end
      $finish;
   end

endmodule : byte_stack_with_reverse_unit_tb

`default_nettype wire
